@@ rtl/core/i2da_pkg.sv @@
`timescale 1ns / 1ps

package i2da_pkg;

  localparam int VALUE_WIDTH_DEF = 64;
  localparam int IN_BITS         = 64;

  localparam logic [7:0] ASCII_ZERO  = 8'd48;
  localparam logic [7:0] ASCII_MINUS = 8'd45;

  typedef struct packed {
    logic [IN_BITS-1:0] value_bits;
    logic               is_signed;
  } in_req_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last_char;
  } out_rsp_t;

  // Commands from the sequencer to the conversion unit.
  typedef struct packed {
    logic load;
    logic shift;
  } bcd_ctrl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONVERT,
    ST_SKIP,
    ST_SIGN,
    ST_EMIT
  } state_t;

endpackage

@@ rtl/core/i2da_bcd_conv.sv @@
`timescale 1ns / 1ps

// Shift-add-3 binary to BCD converter, one input bit per cycle.
// After conversion, the digit register shifts left one digit per request
// so the sequencer always reads the most significant digit at the top.
module i2da_bcd_conv #(
  parameter int VALUE_WIDTH = i2da_pkg::VALUE_WIDTH_DEF,
  parameter int DIGITS      = 20
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  i2da_pkg::bcd_ctrl_t    ctrl,
  input  logic [VALUE_WIDTH-1:0] mag,
  output logic                   done,
  output logic [3:0]             top_digit
);

  localparam int BCD_W = 4 * DIGITS;
  localparam int CNT_W = $clog2(VALUE_WIDTH + 1);

  logic [VALUE_WIDTH-1:0] bin_r, bin_nxt;
  logic [BCD_W-1:0]       bcd_r, bcd_nxt;
  logic [CNT_W-1:0]       count_r, count_nxt;
  logic                   run_r, run_nxt;
  logic [BCD_W-1:0]       adj;

  // Correct every digit that would overflow on doubling.
  always_comb begin
    for (int i = 0; i < DIGITS; i++) begin
      if (bcd_r[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = bcd_r[4*i +: 4] + 4'd3;
      end else begin
        adj[4*i +: 4] = bcd_r[4*i +: 4];
      end
    end
  end

  always_comb begin
    bin_nxt   = bin_r;
    bcd_nxt   = bcd_r;
    count_nxt = count_r;
    run_nxt   = run_r;
    if (ctrl.load) begin
      bin_nxt   = mag;
      bcd_nxt   = '0;
      count_nxt = CNT_W'(VALUE_WIDTH);
      run_nxt   = 1'b1;
    end else if (run_r) begin
      bcd_nxt   = {adj[BCD_W-2:0], bin_r[VALUE_WIDTH-1]};
      bin_nxt   = {bin_r[VALUE_WIDTH-2:0], 1'b0};
      count_nxt = count_r - 1'b1;
      if (count_r == CNT_W'(1)) begin
        run_nxt = 1'b0;
      end
    end else if (ctrl.shift) begin
      bcd_nxt = {bcd_r[BCD_W-5:0], 4'd0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r   <= 1'b0;
      count_r <= '0;
    end else begin
      run_r   <= run_nxt;
      count_r <= count_nxt;
    end
    bin_r <= bin_nxt;
    bcd_r <= bcd_nxt;
  end

  assign done      = run_r && (count_r == CNT_W'(1));
  assign top_digit = bcd_r[BCD_W-1 -: 4];

endmodule

@@ rtl/core/integer_to_decimal_ascii_core.sv @@
`timescale 1ns / 1ps

// Integer to decimal ASCII converter. Pulse start with a value while busy is
// low; the block then emits the decimal text one character per cycle on
// out_rsp, each marked by out_valid for exactly one cycle, most significant
// character first, with a leading '-' for negative signed values and
// last_char set on the final character. The receiver cannot stall: it must
// take every character in the cycle it appears. A request occupies the block
// first for the shift-add-3 conversion of every input bit, then for a pass
// over the BCD digits that skips leading zeros and emits the rest, with a
// minus sign emitted before the first digit for a negative value.
// busy is high for that whole span and no new request is taken.
module integer_to_decimal_ascii_core #(
  parameter int VALUE_WIDTH = i2da_pkg::VALUE_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  i2da_pkg::in_req_t  in_req,
  output logic               out_valid,
  output i2da_pkg::out_rsp_t out_rsp
);

  // Enough decimal digits for any VALUE_WIDTH-bit magnitude.
  localparam int DIGITS = (VALUE_WIDTH * 30103) / 100000 + 1;
  localparam int REM_W  = $clog2(DIGITS + 1);

  i2da_pkg::state_t    state_r, state_nxt;
  logic                neg_r, neg_nxt;
  logic [REM_W-1:0]    remain_r, remain_nxt;
  i2da_pkg::bcd_ctrl_t ctrl;
  logic                conv_done;
  logic [3:0]          top_digit;
  logic [VALUE_WIDTH-1:0] raw;
  logic [VALUE_WIDTH-1:0] mag;
  logic                in_neg;
  logic                accept;

  assign accept = start && !busy;

  // Form the magnitude; the most negative value negates to itself, which
  // read unsigned is exactly its magnitude.
  assign raw    = in_req.value_bits[VALUE_WIDTH-1:0];
  assign in_neg = in_req.is_signed && raw[VALUE_WIDTH-1];
  assign mag    = in_neg ? (~raw + 1'b1) : raw;

  i2da_bcd_conv #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .DIGITS      (DIGITS)
  ) u_conv (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (ctrl),
    .mag       (mag),
    .done      (conv_done),
    .top_digit (top_digit)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      i2da_pkg::ST_IDLE: begin
        if (accept) begin
          state_nxt = i2da_pkg::ST_CONVERT;
        end
      end
      i2da_pkg::ST_CONVERT: begin
        if (conv_done) begin
          state_nxt = i2da_pkg::ST_SKIP;
        end
      end
      i2da_pkg::ST_SKIP: begin
        // Hold while leading zeros remain, but always keep one digit.
        if (top_digit != 4'd0 || remain_r == REM_W'(1)) begin
          state_nxt = neg_r ? i2da_pkg::ST_SIGN : i2da_pkg::ST_EMIT;
        end
      end
      i2da_pkg::ST_SIGN: begin
        state_nxt = i2da_pkg::ST_EMIT;
      end
      i2da_pkg::ST_EMIT: begin
        if (remain_r == REM_W'(1)) begin
          state_nxt = i2da_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = i2da_pkg::ST_IDLE;
      end
    endcase
  end

  // Outputs and datapath control.
  always_comb begin
    busy              = (state_r != i2da_pkg::ST_IDLE);
    out_valid         = 1'b0;
    out_rsp.char_code = i2da_pkg::ASCII_ZERO + {4'd0, top_digit};
    out_rsp.last_char = 1'b0;
    ctrl.load         = 1'b0;
    ctrl.shift        = 1'b0;
    neg_nxt           = neg_r;
    remain_nxt        = remain_r;
    case (state_r)
      i2da_pkg::ST_IDLE: begin
        if (start) begin
          ctrl.load  = 1'b1;
          neg_nxt    = in_neg;
          remain_nxt = REM_W'(DIGITS);
        end
      end
      i2da_pkg::ST_SKIP: begin
        // Drop a leading zero digit.
        if (top_digit == 4'd0 && remain_r != REM_W'(1)) begin
          ctrl.shift = 1'b1;
          remain_nxt = remain_r - 1'b1;
        end
      end
      i2da_pkg::ST_SIGN: begin
        out_valid         = 1'b1;
        out_rsp.char_code = i2da_pkg::ASCII_MINUS;
      end
      i2da_pkg::ST_EMIT: begin
        // Emit the top digit and advance to the next one.
        out_valid         = 1'b1;
        out_rsp.last_char = (remain_r == REM_W'(1));
        ctrl.shift        = 1'b1;
        remain_nxt        = remain_r - 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= i2da_pkg::ST_IDLE;
      neg_r    <= 1'b0;
      remain_r <= '0;
    end else begin
      state_r  <= state_nxt;
      neg_r    <= neg_nxt;
      remain_r <= remain_nxt;
    end
  end

  // A character only appears while a request is in progress.
  a_valid_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("character emitted while idle");

  // The last character frees the block.
  a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_rsp.last_char |=> !busy)
    else $error("block still busy after last character");

  // Characters of one number come out back to back.
  a_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_rsp.last_char |=> out_valid)
    else $error("gap inside a number's text");

  // An accepted request makes the block busy.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("request accepted but block not busy");

  // The digit counter never runs out while emitting.
  a_remain_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == i2da_pkg::ST_EMIT) || (state_r == i2da_pkg::ST_SKIP)
      |-> remain_r != '0)
    else $error("digit counter empty while emitting");

endmodule
